// ===== sv/ooat_pkg.sv =====
// ----------------------------------------------------------------------------
// ooat_pkg
// Shared widths, register indexes and the configuration bundle for the
// one-at-a-time hash bucket block.
// ----------------------------------------------------------------------------
`default_nettype none

package ooat_pkg;

   localparam int HASH_W       = 32;
   localparam int BYTE_W       = 8;
   localparam int COUNT_W      = 17;
   localparam int BUCKET_W     = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = 2;
   localparam int QUEUE_CNT_W  = 3;

   localparam logic [COUNT_W-1:0] MAX_BUCKETS     = 17'd65536;
   localparam logic [COUNT_W-1:0] BUCKET_COUNT_RST = 17'd1024;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_BUCKET_COUNT     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BYTE_SIGN_EXTEND = 2'd1;

   // Configuration as seen by the mixer and the reducer.
   typedef struct packed {
      logic [COUNT_W-1:0] divisor;      // already saturated to MAX_BUCKETS
      logic               sign_extend;
   } cfg_type;

endpackage

`default_nettype wire

// ===== sv/one_at_a_time_hash_bucket.sv =====
// ----------------------------------------------------------------------------
// one_at_a_time_hash_bucket
// One-at-a-time hash of a byte stream, reduced to a bucket index per key.
// ----------------------------------------------------------------------------
// Key bytes are taken at one per clock cycle and mixed into the running hash
// as they arrive. Each completed key (the transaction with tlast set) is
// placed in a four-entry queue; the reducer behind it works on one key at a
// time (it takes the key from the queue, applies the final avalanche, runs
// the bit-serial modulo divider and then offers its response transaction
// until it is taken), so keys whose bytes take longer to arrive than the
// reducer spends on a key run at one byte per cycle, and shorter keys are
// held off whenever the queue fills. A key with no bytes is sent as one
// transaction with tlast set and tuser clear. Configuration writes are
// accepted at all times but must only be made while no key is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module one_at_a_time_hash_bucket
   import ooat_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Input stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] key_byte
   input  wire logic                   req_tuser,   // [0] byte_present
   input  wire logic                   req_tlast,   // last_byte
   // Result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [47:0]                 rsp_tdata,   // [15:0] bucket_index, [47:16] full_hash
   // Register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COUNT_W-1:0]     csr_data
);

   logic [COUNT_W-1:0]  bucket_count_ff;
   logic                sign_extend_ff;
   cfg_type             cfg;
   logic                push_valid;
   logic                push_ready;
   logic [HASH_W-1:0]   push_hash;
   logic                q_valid;
   logic                q_ready;
   logic [HASH_W-1:0]   q_hash;
   logic [BUCKET_W-1:0] bucket;
   logic [HASH_W-1:0]   full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_COUNT_RST;
         sign_extend_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_BUCKET_COUNT:     bucket_count_ff <= csr_data;
            REG_BYTE_SIGN_EXTEND: sign_extend_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign cfg.divisor     = (bucket_count_ff > MAX_BUCKETS) ? MAX_BUCKETS : bucket_count_ff;
   assign cfg.sign_extend = sign_extend_ff;

   ooat_mixer u_mixer (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_present (req_tuser),
      .in_last    (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_hash  (push_hash)
   );

   ooat_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_data  (push_hash),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_hash)
   );

   ooat_reducer u_reducer (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_hash     (q_hash),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_bucket (bucket),
      .out_full   (full)
   );

   assign rsp_tdata = {full, bucket};

endmodule

`default_nettype wire

// ===== sv/ooat_mixer.sv =====
// ----------------------------------------------------------------------------
// ooat_mixer
// Front part: mixes accepted key bytes into the running hash one byte per
// cycle if the queue has room; pushes the unfinalised hash per completed key.
// ----------------------------------------------------------------------------
`default_nettype none

module ooat_mixer
   import ooat_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [BYTE_W-1:0] in_byte,
   input  wire logic              in_present,
   input  wire logic              in_last,
   output logic                   push_valid,
   input  wire logic              push_ready,
   output logic [HASH_W-1:0]      push_hash
);

   logic [HASH_W-1:0] running_hash_ff;
   logic [HASH_W-1:0] running_hash_in;
   logic [HASH_W-1:0] ext_byte;
   logic [HASH_W-1:0] sum_a;
   logic [HASH_W-1:0] sum_b;
   logic [HASH_W-1:0] mixed;
   logic              accept;

   // Only a key end needs queue space, but holding off every byte while the
   // queue is full keeps the handshake independent of the payload.
   assign in_ready = push_ready;
   assign accept   = in_valid && in_ready;

   assign ext_byte = (cfg.sign_extend && in_byte[BYTE_W-1]) ?
                     {{(HASH_W-BYTE_W){1'b1}}, in_byte} :
                     {{(HASH_W-BYTE_W){1'b0}}, in_byte};

   always_comb begin
      sum_a = running_hash_ff + ext_byte;
      sum_b = sum_a + (sum_a << 10);
      mixed = in_present ? (sum_b ^ (sum_b >> 6)) : running_hash_ff;
   end

   assign push_valid = accept && in_last;
   assign push_hash  = mixed;

   always_comb begin
      running_hash_in = running_hash_ff;
      if (accept) begin
         running_hash_in = in_last ? '0 : mixed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff <= '0;
      end else begin
         running_hash_ff <= running_hash_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ooat_queue.sv =====
// ----------------------------------------------------------------------------
// ooat_queue
// Short first-in first-out queue of completed key hashes between the mixer
// and the reducer.
// ----------------------------------------------------------------------------
`default_nettype none

module ooat_queue
   import ooat_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_valid,
   output logic                   wr_ready,
   input  wire logic [HASH_W-1:0] wr_data,
   output logic                   rd_valid,
   input  wire logic              rd_ready,
   output logic [HASH_W-1:0]      rd_data
);

   logic [HASH_W-1:0]      mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic                   do_wr;
   logic                   do_rd;

   assign wr_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/ooat_reducer.sv =====
// ----------------------------------------------------------------------------
// ooat_reducer
// Back part: applies the final avalanche to a queued hash, reduces it modulo
// the bucket count with a bit-serial restoring divider and holds the result
// until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ooat_reducer
   import ooat_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              q_valid,
   output logic                   q_ready,
   input  wire logic [HASH_W-1:0] q_hash,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [BUCKET_W-1:0]    out_bucket,
   output logic [HASH_W-1:0]      out_full
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIN_A,
      ST_FIN_B,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [HASH_W-1:0]  hash_ff;
   logic [HASH_W-1:0]  quot_ff;
   logic [COUNT_W-1:0] rem_ff;
   logic [4:0]         bit_cnt_ff;
   logic [BUCKET_W-1:0] bucket_ff;
   logic               out_valid_ff;

   logic [HASH_W-1:0]  fin_a1;
   logic [HASH_W-1:0]  fin_a;
   logic [HASH_W-1:0]  fin_b;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W:0]   diff;
   logic [COUNT_W-1:0] rem_in;

   always_comb begin
      fin_a1 = hash_ff + (hash_ff << 3);
      fin_a  = fin_a1 ^ (fin_a1 >> 11);
      fin_b  = hash_ff + (hash_ff << 15);
   end

   // One restoring step: the partial remainder stays below the divisor,
   // so the shifted value is below twice the divisor and a single
   // subtraction suffices.
   always_comb begin
      trial  = {rem_ff, quot_ff[HASH_W-1]};
      diff   = trial - {1'b0, cfg.divisor};
      rem_in = (trial >= {1'b0, cfg.divisor}) ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
   end

   assign q_ready    = (state_ff == ST_IDLE);
   assign out_valid  = out_valid_ff;
   assign out_bucket = bucket_ff;
   assign out_full   = hash_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  hash_ff  <= q_hash;
                  state_ff <= ST_FIN_A;
               end
            end
            ST_FIN_A: begin
               hash_ff  <= fin_a;
               state_ff <= ST_FIN_B;
            end
            ST_FIN_B: begin
               hash_ff    <= fin_b;
               quot_ff    <= fin_b;
               rem_ff     <= '0;
               bit_cnt_ff <= 5'd31;
               state_ff   <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               rem_ff     <= rem_in;
               quot_ff    <= quot_ff << 1;
               bit_cnt_ff <= bit_cnt_ff - 1'b1;
               if (bit_cnt_ff == '0) begin
                  // A bucket count of zero maps every key to bucket zero.
                  bucket_ff    <= (cfg.divisor == '0) ? '0 : rem_in[BUCKET_W-1:0];
                  out_valid_ff <= 1'b1;
                  state_ff     <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_ready) begin
                  out_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               out_valid_ff <= 1'b0;
               state_ff     <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== sv/ooat_checker.sv =====
// ----------------------------------------------------------------------------
// ooat_checker
// Port-level checks on the one-at-a-time hash bucket block.
// ----------------------------------------------------------------------------
`default_nettype none

module ooat_checker
   import ooat_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic [7:0]             req_tdata,
   input wire logic                   req_tuser,
   input wire logic                   req_tlast,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [47:0]            rsp_tdata,
   input wire logic                   csr_valid,
   input wire logic                   csr_ready,
   input wire logic [CSR_INDEX_W-1:0] csr_index,
   input wire logic [COUNT_W-1:0]     csr_data
);

   logic [COUNT_W-1:0] eff_count_ff;

   // Mirror of the effective bucket count, taken from register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         eff_count_ff <= BUCKET_COUNT_RST;
      end else if (csr_valid && csr_ready && csr_index == REG_BUCKET_COUNT) begin
         eff_count_ff <= (csr_data > MAX_BUCKETS) ? MAX_BUCKETS : csr_data;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response offered straight after reset");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> !rsp_tvalid)
      else $error("response repeated in the cycle after it was taken");

   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && eff_count_ff != '0 |-> {1'b0, rsp_tdata[15:0]} < eff_count_ff)
      else $error("bucket index not below the bucket count");

   a_zero_hash: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[47:16] == '0 |-> rsp_tdata[15:0] == '0)
      else $error("zero hash mapped to a non-zero bucket");

endmodule

bind one_at_a_time_hash_bucket ooat_checker u_ooat_checker (.*);

`default_nettype wire
